>>> src/touch_sample_trimmed_mean_filter_top_assert.svh
// Assertion macros shared by the touch sample filter modules.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TOUCH_SAMPLE_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define TSF_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tsf assertion failed");

// Antecedent implies consequent at the same edge.
`define TSF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsf implication failed");

`endif

>>> src/tsf_pkg.sv
// Shared types and constants of the touch sample trimmed mean filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int GROUP_SIZE  = 5;
	localparam int TRIM_COUNT  = GROUP_SIZE - 2;
	localparam int TWO_GROUPS  = 2 * GROUP_SIZE;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(GROUP_SIZE);
	localparam int TRIM_W = SAMPLE_BITS + $clog2(TRIM_COUNT);
	localparam int CNT_W  = $clog2(TWO_GROUPS);

	// floor(s / TRIM_COUNT) == (s * RECIP_M) >> RECIP_SHIFT for every s below 2**TRIM_W
	localparam int RECIP_SHIFT = TRIM_W + $clog2(TRIM_COUNT);
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = TRIM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((1 << RECIP_SHIFT) + TRIM_COUNT - 1) / TRIM_COUNT);

	localparam logic [SAMPLE_BITS-1:0] TOL_RESET = SAMPLE_BITS'(50);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [TRIM_W-1:0]      trim_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef struct packed {
		sample_t raw_x;
		sample_t raw_y;
	} in_item_t;

	typedef struct packed {
		sample_t pos_x;
		sample_t pos_y;
		logic    agreed;
	} res_item_t;

	// one finished group: trimmed sums, and whether it closes the pair
	typedef struct packed {
		logic  second;
		trim_t x;
		trim_t y;
	} grp_t;

	// one finished group: trimmed means
	typedef struct packed {
		logic    second;
		sample_t x;
		sample_t y;
	} avg_t;

endpackage

>>> src/tsf_accum.sv
// Running sum, minimum and maximum per axis over one group of samples.
// Emits the trimmed sums when a group closes. Depends on tsf_pkg.
`timescale 1ns / 1ps
`include "touch_sample_trimmed_mean_filter_top_assert.svh"

module tsf_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  tsf_pkg::in_item_t item_s1,
	output logic             valid_s2,
	output tsf_pkg::grp_t    grp_s2
);

	tsf_pkg::cnt_t    cnt_q;
	tsf_pkg::sum_t    x_sum_q, y_sum_q;
	tsf_pkg::sample_t x_min_q, x_max_q, y_min_q, y_max_q;

	logic [tsf_pkg::CNT_W:0] cnt_n;
	tsf_pkg::sum_t    x_sum_n, y_sum_n;
	tsf_pkg::sample_t x_min_n, x_max_n, y_min_n, y_max_n;
	tsf_pkg::sum_t    x_trim, y_trim;
	logic             first_end, second_end, group_end;

	always_comb begin
		x_sum_n = x_sum_q + tsf_pkg::SUM_W'(item_s1.raw_x);
		y_sum_n = y_sum_q + tsf_pkg::SUM_W'(item_s1.raw_y);
		x_min_n = (item_s1.raw_x < x_min_q) ? item_s1.raw_x : x_min_q;
		x_max_n = (item_s1.raw_x > x_max_q) ? item_s1.raw_x : x_max_q;
		y_min_n = (item_s1.raw_y < y_min_q) ? item_s1.raw_y : y_min_q;
		y_max_n = (item_s1.raw_y > y_max_q) ? item_s1.raw_y : y_max_q;
		x_trim  = x_sum_n - tsf_pkg::SUM_W'(x_min_n) - tsf_pkg::SUM_W'(x_max_n);
		y_trim  = y_sum_n - tsf_pkg::SUM_W'(y_min_n) - tsf_pkg::SUM_W'(y_max_n);
		cnt_n      = {1'b0, cnt_q} + (tsf_pkg::CNT_W+1)'(1);
		first_end  = (cnt_n == (tsf_pkg::CNT_W+1)'(tsf_pkg::GROUP_SIZE));
		second_end = (cnt_n == (tsf_pkg::CNT_W+1)'(tsf_pkg::TWO_GROUPS));
		group_end  = first_end | second_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			x_sum_q  <= '0;
			y_sum_q  <= '0;
			x_min_q  <= '1;
			y_min_q  <= '1;
			x_max_q  <= '0;
			y_max_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 & group_end;
			if (valid_s1) begin
				cnt_q <= second_end ? '0 : cnt_n[tsf_pkg::CNT_W-1:0];
				if (group_end) begin
					x_sum_q <= '0;
					y_sum_q <= '0;
					x_min_q <= '1;
					y_min_q <= '1;
					x_max_q <= '0;
					y_max_q <= '0;
				end else begin
					x_sum_q <= x_sum_n;
					y_sum_q <= y_sum_n;
					x_min_q <= x_min_n;
					y_min_q <= y_min_n;
					x_max_q <= x_max_n;
					y_max_q <= y_max_n;
				end
			end
		end
	end

	// trimmed sums always fit TRIM_W
	always_ff @(posedge clk) begin
		if (valid_s1 && group_end) begin
			grp_s2.second <= second_end;
			grp_s2.x      <= x_trim[tsf_pkg::TRIM_W-1:0];
			grp_s2.y      <= y_trim[tsf_pkg::TRIM_W-1:0];
		end
	end

	`TSF_ASSERT(a_cnt_range, cnt_q < tsf_pkg::CNT_W'(tsf_pkg::TWO_GROUPS))

endmodule

>>> src/tsf_div.sv
// Divides the trimmed sums by the number of kept samples.
// Reciprocal multiply, exact over the trimmed sum range. Depends on tsf_pkg.
`timescale 1ns / 1ps

module tsf_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s2,
	input  tsf_pkg::grp_t grp_s2,
	output logic          valid_s3,
	output tsf_pkg::avg_t avg_s3
);

	logic [tsf_pkg::PROD_W-1:0] x_prod, y_prod;

	assign x_prod = tsf_pkg::PROD_W'(grp_s2.x) * tsf_pkg::PROD_W'(tsf_pkg::RECIP_M);
	assign y_prod = tsf_pkg::PROD_W'(grp_s2.y) * tsf_pkg::PROD_W'(tsf_pkg::RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			avg_s3.second <= grp_s2.second;
			avg_s3.x      <= x_prod[tsf_pkg::RECIP_SHIFT +: tsf_pkg::SAMPLE_BITS];
			avg_s3.y      <= y_prod[tsf_pkg::RECIP_SHIFT +: tsf_pkg::SAMPLE_BITS];
		end
	end

endmodule

>>> src/tsf_check.sv
// Holds the first group's means and checks the second group against them.
// Builds the result item for the output queue. Depends on tsf_pkg.
`timescale 1ns / 1ps

module tsf_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s3,
	input  tsf_pkg::avg_t      avg_s3,
	input  tsf_pkg::sample_t   tolerance,
	output logic               push,
	output tsf_pkg::res_item_t res
);

	tsf_pkg::sample_t first_x_q, first_y_q;
	tsf_pkg::sample_t diff_x, diff_y;
	logic [tsf_pkg::SAMPLE_BITS:0] sum_x, sum_y;
	logic ok;

	always_comb begin
		diff_x = (avg_s3.x > first_x_q) ? (avg_s3.x - first_x_q) : (first_x_q - avg_s3.x);
		diff_y = (avg_s3.y > first_y_q) ? (avg_s3.y - first_y_q) : (first_y_q - avg_s3.y);
		ok     = (diff_x < tolerance) && (diff_y < tolerance);
		sum_x  = {1'b0, first_x_q} + {1'b0, avg_s3.x};
		sum_y  = {1'b0, first_y_q} + {1'b0, avg_s3.y};
		push   = valid_s3 & avg_s3.second;
		res.agreed = ok;
		res.pos_x  = ok ? sum_x[tsf_pkg::SAMPLE_BITS:1] : '0;
		res.pos_y  = ok ? sum_y[tsf_pkg::SAMPLE_BITS:1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
		end else if (valid_s3 && !avg_s3.second) begin
			first_x_q <= avg_s3.x;
			first_y_q <= avg_s3.y;
		end
	end

endmodule

>>> src/tsf_outq.sv
// Two-slot result queue: a head register and a spare slot behind it.
// Lets the filter keep taking samples while a result waits. Depends on tsf_pkg.
`timescale 1ns / 1ps
`include "touch_sample_trimmed_mean_filter_top_assert.svh"

module tsf_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsf_pkg::res_item_t wdata,
	output logic               valid,
	input  logic               ready,
	output tsf_pkg::res_item_t rdata,
	output logic               full
);

	tsf_pkg::res_item_t head_q, spare_q;
	logic head_vld_q, spare_vld_q;
	logic pop;

	assign pop   = ready & head_vld_q;
	assign valid = head_vld_q;
	assign rdata = head_q;
	assign full  = head_vld_q & spare_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= 1'b0;
			spare_vld_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b11: begin
					head_vld_q <= 1'b1;
				end
				2'b01: begin
					head_vld_q  <= spare_vld_q;
					spare_vld_q <= 1'b0;
				end
				2'b10: begin
					if (head_vld_q) begin
						spare_vld_q <= 1'b1;
					end else begin
						head_vld_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (spare_vld_q) begin
					head_q  <= spare_q;
					spare_q <= wdata;
				end else begin
					head_q <= wdata;
				end
			end
			2'b01: begin
				head_q <= spare_q;
			end
			2'b10: begin
				if (head_vld_q) begin
					spare_q <= wdata;
				end else begin
					head_q <= wdata;
				end
			end
			default: begin
			end
		endcase
	end

	`TSF_ASSERT_IMPL(a_no_overflow, push, !full)
	`TSF_ASSERT_IMPL(a_spare_behind_head, spare_vld_q, head_vld_q)

endmodule

>>> src/touch_sample_trimmed_mean_filter_top.sv
// Touch sample trimmed mean filter. Takes one raw X/Y sample per cycle; every five samples
// form a group whose smallest and largest value per axis are dropped and the middle three
// averaged. Each pair of groups yields one result item: the mean of both group averages
// with agreed=1 when they differ by less than the tolerance on both axes, else zeros with
// agreed=0. Rate is one sample per cycle, set by the running sum/min/max stage.
// The sample channel stalls only on the last sample of a pair while two results still
// wait in the two-slot output queue. The tolerance (reset 50) is written through cfg;
// the user must write it only while no pair is in flight, which the block does not
// enforce. No setup pass. A result passes item_s1, grp_s2, avg_s3 and the queue head.
// Depends on tsf_pkg and the tsf_accum, tsf_div, tsf_check and tsf_outq modules.
`timescale 1ns / 1ps
`include "touch_sample_trimmed_mean_filter_top_assert.svh"

module touch_sample_trimmed_mean_filter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  tsf_pkg::in_item_t  sample,
	output logic               result_valid,
	input  logic               result_ready,
	output tsf_pkg::res_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  tsf_pkg::sample_t   cfg_data
);

	tsf_pkg::sample_t   tol_q;
	tsf_pkg::cnt_t      in_cnt_q;
	logic               valid_s1, valid_s2, valid_s3;
	tsf_pkg::in_item_t  item_s1;
	tsf_pkg::grp_t      grp_s2;
	tsf_pkg::avg_t      avg_s3;
	logic               push, q_full, take;
	tsf_pkg::res_item_t res;

	assign cfg_ready = 1'b1;

	// the last item of a pair makes a result; a free queue slot is needed for it
	assign sample_ready = (in_cnt_q != tsf_pkg::CNT_W'(tsf_pkg::TWO_GROUPS - 1)) | ~q_full;
	assign take         = sample_valid & sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= tsf_pkg::TOL_RESET;
			in_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (take) begin
				in_cnt_q <= (in_cnt_q == tsf_pkg::CNT_W'(tsf_pkg::TWO_GROUPS - 1)) ? '0 :
					in_cnt_q + tsf_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= sample;
		end
	end

	tsf_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.valid_s2 (valid_s2),
		.grp_s2   (grp_s2)
	);

	tsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.grp_s2   (grp_s2),
		.valid_s3 (valid_s3),
		.avg_s3   (avg_s3)
	);

	tsf_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.avg_s3    (avg_s3),
		.tolerance (tol_q),
		.push      (push),
		.res       (res)
	);

	tsf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res),
		.valid  (result_valid),
		.ready  (result_ready),
		.rdata  (result),
		.full   (q_full)
	);

	`TSF_ASSERT_IMPL(a_disagree_zero, result_valid && !result.agreed,
		result.pos_x == '0 && result.pos_y == '0)
	`TSF_ASSERT_IMPL(a_result_held, $past(result_valid & ~result_ready),
		result_valid && result == $past(result))

endmodule
